### hw/rtl/bubble_sorter_bidirectional_core_defines.svh
// assertion macros for the bidirectional bubble sorter checker
// no dependencies; expects clk and arst_n in the scope of each use
`ifndef BUBBLE_SORTER_BIDIRECTIONAL_CORE_DEFINES_SVH
`define BUBBLE_SORTER_BIDIRECTIONAL_CORE_DEFINES_SVH

// plain property, sampled on clk, off while in reset
`define BSB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("bsb port check failed");

// same-cycle implication
`define BSB_ASSERT_IMP(lbl, ante, cons) `BSB_ASSERT(lbl, (ante) |-> (cons))

// next-cycle implication
`define BSB_ASSERT_NXT(lbl, ante, cons) `BSB_ASSERT(lbl, (ante) |=> (cons))

`endif

### hw/rtl/bsb_pkg.sv
// shared types and constants of the bidirectional bubble sorter
// no dependencies
package bsb_pkg;

	// fixed width of the sample and sorted_value ports
	localparam int SAMPLE_BITS = 32;

	// defaults for the top level parameters
	localparam int MAX_ITEMS_DEF  = 32;
	localparam int VALUE_BITS_DEF = 32;

	// per-cycle command from the controller to every cell
	typedef struct packed {
		logic load;
		logic sort;
		logic shift;
		logic parity;
		logic descending;
	} cell_ctrl_t;

	// result transaction flags, registered in the controller
	typedef struct packed {
		logic strobe;
		logic last;
		logic dropped;
	} out_info_t;

endpackage

### hw/rtl/bsb_cell.sv
// one cell of the sorting row: holds a value, loads, compare-exchanges, shifts
// depends on bsb_pkg
module bsb_cell #(
	parameter int INDEX      = 0,
	parameter int VALUE_BITS = bsb_pkg::VALUE_BITS_DEF,
	parameter int IDX_W      = 5,
	parameter bit HAS_RIGHT  = 1'b1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bsb_pkg::cell_ctrl_t          ctrl,
	input  logic [IDX_W-1:0]             load_idx,
	input  logic [VALUE_BITS-1:0]        load_value,
	input  logic [VALUE_BITS-1:0]        left_val,
	input  logic                         swap_from_left,
	input  logic [VALUE_BITS-1:0]        right_val,
	input  logic                         right_vld,
	output logic [VALUE_BITS-1:0]        val,
	output logic                         vld,
	output logic                         swap_right
);

	localparam logic ODD = 1'(INDEX % 2);

	logic [VALUE_BITS-1:0] val_q;
	logic                  vld_q;
	logic                  load_hit;
	logic                  is_lower;
	logic                  right_less;
	logic                  own_less;

	assign load_hit = ctrl.load && (load_idx == IDX_W'(INDEX));

	// this cell is the lower half of a pair in the current round
	assign is_lower = HAS_RIGHT && (ctrl.parity == ODD);

	// signed compares, strict only, so equal values never move
	assign right_less = $signed(right_val) < $signed(val_q);
	assign own_less   = $signed(val_q) < $signed(right_val);

	assign swap_right = ctrl.sort && is_lower && vld_q && right_vld &&
		(ctrl.descending ? own_less : right_less);

	// value register
	always_ff @(posedge clk) begin
		if (load_hit) begin
			val_q <= load_value;
		end else if (ctrl.shift) begin
			val_q <= right_val;
		end else if (swap_right) begin
			val_q <= right_val;
		end else if (swap_from_left) begin
			val_q <= left_val;
		end
	end

	// occupancy bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load_hit) begin
			vld_q <= 1'b1;
		end else if (ctrl.shift) begin
			vld_q <= right_vld;
		end
	end

	assign val = val_q;
	assign vld = vld_q;

endmodule

### hw/rtl/bsb_ctrl.sv
// sequencer of the sorter: load count, sort rounds, drain of the results
// depends on bsb_pkg
module bsb_ctrl #(
	parameter int MAX_ITEMS = bsb_pkg::MAX_ITEMS_DEF,
	parameter int IDX_W     = $clog2(MAX_ITEMS),
	parameter int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  final_item,
	input  logic                  descending,
	output logic                  busy,
	output bsb_pkg::cell_ctrl_t   ctrl,
	output logic [IDX_W-1:0]      load_idx,
	output bsb_pkg::out_info_t    info
);

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_SORT  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   round_q;
	logic               ovf_q;
	bsb_pkg::out_info_t info_q;
	logic               accept;
	logic               full;

	assign accept = start && (state_q == ST_LOAD);
	assign full   = count_q == CNT_W'(MAX_ITEMS);
	assign busy   = state_q != ST_LOAD;

	// command to the cell row
	assign ctrl.load       = accept && !full;
	assign ctrl.sort       = state_q == ST_SORT;
	assign ctrl.shift      = state_q == ST_DRAIN;
	assign ctrl.parity     = round_q[0];
	assign ctrl.descending = descending;
	assign load_idx        = count_q[IDX_W-1:0];

	// state, counters and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			round_q <= '0;
			ovf_q   <= 1'b0;
			info_q  <= '0;
		end else begin
			info_q.strobe <= state_q == ST_DRAIN;
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (!full) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (final_item) begin
							state_q <= ST_SORT;
							round_q <= '0;
						end
					end
				end
				ST_SORT: begin
					round_q <= round_q + CNT_W'(1);
					if (round_q == count_q - CNT_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					info_q.last    <= count_q == CNT_W'(1);
					info_q.dropped <= ovf_q;
					count_q        <= count_q - CNT_W'(1);
					if (count_q == CNT_W'(1)) begin
						state_q <= ST_LOAD;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign info = info_q;

endmodule

### hw/rtl/bubble_sorter_bidirectional_core.sv
// Set sorter: a row of cells loaded one value per cycle (busy low while loading).
// After the closing transaction the row runs n odd-even transposition rounds (n = values
// held), then shifts out one result per cycle from the head cell through a result register;
// busy drops with the last result. The receiver cannot stall. arst_n clears the controller,
// occupancy bits and descending.
// depends on bsb_pkg, bsb_cell, bsb_ctrl
module bubble_sorter_bidirectional_core #(
	parameter int MAX_ITEMS  = bsb_pkg::MAX_ITEMS_DEF,
	parameter int VALUE_BITS = bsb_pkg::VALUE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_wdata,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [bsb_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                               final_item,
	output logic                               result_strobe,
	output logic signed [bsb_pkg::SAMPLE_BITS-1:0] sorted_value,
	output logic                               end_of_set,
	output logic                               dropped
);

	localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int SB    = bsb_pkg::SAMPLE_BITS;

	logic                  descending_q;
	bsb_pkg::cell_ctrl_t   ctrl;
	bsb_pkg::out_info_t    info;
	logic [IDX_W-1:0]      load_idx;
	logic [VALUE_BITS-1:0] load_value;
	logic [VALUE_BITS-1:0] head_q;
	logic [VALUE_BITS-1:0] val_w  [MAX_ITEMS];
	logic                  vld_w  [MAX_ITEMS];
	logic                  swap_w [MAX_ITEMS];

	// sort order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q <= 1'b0;
		end else if (cfg_we) begin
			descending_q <= cfg_wdata;
		end
	end

	// sample into the stored width, result back to the port width
	generate
		if (VALUE_BITS < SB) begin : g_narrow
			assign load_value   = sample[VALUE_BITS-1:0];
			assign sorted_value = {{(SB - VALUE_BITS){head_q[VALUE_BITS-1]}}, head_q};
		end else if (VALUE_BITS == SB) begin : g_equal
			assign load_value   = sample;
			assign sorted_value = head_q;
		end else begin : g_wide
			assign load_value   = {{(VALUE_BITS - SB){1'b0}}, sample};
			assign sorted_value = head_q[SB-1:0];
		end
	endgenerate

	bsb_ctrl #(
		.MAX_ITEMS (MAX_ITEMS),
		.IDX_W     (IDX_W),
		.CNT_W     (CNT_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.final_item (final_item),
		.descending (descending_q),
		.busy       (busy),
		.ctrl       (ctrl),
		.load_idx   (load_idx),
		.info       (info)
	);

	// row of cells, each wired to its neighbors
	generate
		for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
			logic [VALUE_BITS-1:0] left_val;
			logic                  left_swap;
			logic [VALUE_BITS-1:0] right_val;
			logic                  right_vld;

			if (k == 0) begin : g_first
				assign left_val  = '0;
				assign left_swap = 1'b0;
			end else begin : g_mid_l
				assign left_val  = val_w[k-1];
				assign left_swap = swap_w[k-1];
			end

			if (k == MAX_ITEMS - 1) begin : g_last
				assign right_val = '0;
				assign right_vld = 1'b0;
			end else begin : g_mid_r
				assign right_val = val_w[k+1];
				assign right_vld = vld_w[k+1];
			end

			bsb_cell #(
				.INDEX      (k),
				.VALUE_BITS (VALUE_BITS),
				.IDX_W      (IDX_W),
				.HAS_RIGHT  (k != MAX_ITEMS - 1)
			) u_cell (
				.clk            (clk),
				.arst_n         (arst_n),
				.ctrl           (ctrl),
				.load_idx       (load_idx),
				.load_value     (load_value),
				.left_val       (left_val),
				.swap_from_left (left_swap),
				.right_val      (right_val),
				.right_vld      (right_vld),
				.val            (val_w[k]),
				.vld            (vld_w[k]),
				.swap_right     (swap_w[k])
			);
		end
	endgenerate

	// result register, taken from the head cell as the row shifts
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			head_q <= val_w[0];
		end
	end

	assign result_strobe = info.strobe;
	assign end_of_set    = info.last;
	assign dropped       = info.dropped;

endmodule

### hw/rtl/bsb_checker.sv
// port-level checks of the bidirectional sorter, bound to the top level
// depends on bubble_sorter_bidirectional_core_defines.svh and the top level
`include "bubble_sorter_bidirectional_core_defines.svh"

module bsb_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic final_item,
	input logic result_strobe,
	input logic end_of_set
);

	// results of a set come on consecutive cycles
	`BSB_ASSERT_NXT(a_burst, result_strobe && !end_of_set, result_strobe)
	// nothing follows the last result of a set at once
	`BSB_ASSERT_NXT(a_gap, result_strobe && end_of_set, !result_strobe)
	// the block is free again only with the last result
	`BSB_ASSERT_IMP(a_free, result_strobe && !busy, end_of_set)
	// a closing transaction starts the sort
	`BSB_ASSERT_NXT(a_close, start && !busy && final_item, busy)
	// an open set keeps taking values
	`BSB_ASSERT_NXT(a_open, start && !busy && !final_item, !busy)

endmodule

bind bubble_sorter_bidirectional_core bsb_checker u_bsb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.final_item    (final_item),
	.result_strobe (result_strobe),
	.end_of_set    (end_of_set)
);

### tb/tb_bubble_sorter_bidirectional_core.sv
// self-checking testbench for the bidirectional set sorter: random sets with overflow
// depends on bsb_pkg and bubble_sorter_bidirectional_core; a scoreboard predicts results
module tb_bubble_sorter_bidirectional_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY      = bsb_pkg::MAX_ITEMS_DEF;
	localparam int W             = bsb_pkg::SAMPLE_BITS;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int MAX_GAP       = 20;
	localparam int SETTLE_CYCLES = 3 * CAPACITY + 8;
	localparam int PHASE_ITEMS   = 120;

	typedef logic signed [W-1:0] q16_t;

	typedef struct packed {
		q16_t value;
		logic last;
		logic drop;
	} sorted_result_t;

	// predicts each closed set and checks results in order
	class sort_scoreboard;
		q16_t           loaded[$];
		bit             overflow;
		bit             descending;
		sorted_result_t expected_sorted[$];
		int             mismatches;
		int             sets;
		int             overflow_sets;
		int             checked;
		int             items;

		function void set_order(bit desc);
			descending = desc;
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= 40)
				$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		// accepted input transaction; a closing one produces the sorted set
		function void note_sample(q16_t v, logic fin);
			q16_t           row[$];
			q16_t           key;
			sorted_result_t r;
			int             i;
			int             j;
			items++;
			if (loaded.size() < CAPACITY)
				loaded.push_back(v);
			else
				overflow = 1;
			if (!fin)
				return;
			row = loaded;
			// stable insertion sort: only a strict order moves a value
			for (i = 1; i < row.size(); i++) begin
				key = row[i];
				j = i - 1;
				while (j >= 0 && (descending ? (row[j] < key) : (row[j] > key))) begin
					row[j + 1] = row[j];
					j--;
				end
				row[j + 1] = key;
			end
			for (i = 0; i < row.size(); i++) begin
				r.value = row[i];
				r.last  = (i == row.size() - 1);
				r.drop  = overflow;
				expected_sorted.push_back(r);
			end
			sets++;
			if (overflow)
				overflow_sets++;
			loaded.delete();
			overflow = 0;
		endfunction

		task check_result(q16_t v, logic eos, logic drp);
			sorted_result_t want;
			checked++;
			if (expected_sorted.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing expected", v));
				return;
			end
			want = expected_sorted.pop_front();
			if (v !== want.value)
				report_mismatch($sformatf("sorted_value %h, want %h", v, want.value));
			if (eos !== want.last)
				report_mismatch($sformatf("end_of_set %b, want %b on %h", eos, want.last, v));
			if (drp !== want.drop)
				report_mismatch($sformatf("dropped %b, want %b on %h", drp, want.drop, v));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic start;
	logic busy;
	q16_t sample;
	logic final_item;
	logic result_strobe;
	q16_t sorted_value;
	logic end_of_set;
	logic dropped;

	sort_scoreboard sb = new();
	int             idle_pct;
	int             cycles;

	bubble_sorter_bidirectional_core #(
		.MAX_ITEMS (CAPACITY),
		.VALUE_BITS(bsb_pkg::VALUE_BITS_DEF)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.busy         (busy),
		.sample       (sample),
		.final_item   (final_item),
		.result_strobe(result_strobe),
		.sorted_value (sorted_value),
		.end_of_set   (end_of_set),
		.dropped      (dropped)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_strobe)
			sb.check_result(sorted_value, end_of_set, dropped);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int draw_gap();
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		return gap;
	endfunction

	// extremes, small values that collide often, or anything
	function automatic q16_t draw_value();
		int r;
		r = $urandom_range(99);
		if (r < 12) begin
			case ($urandom_range(4))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sh0000_0000;
				3: return 32'shffff_ffff;
				default: return 32'sh0000_0001;
			endcase
		end
		if (r < 40)
			return q16_t'($signed($urandom_range(15)) - 8);
		return q16_t'($urandom);
	endfunction

	// mostly short sets, some long, some exactly full, some overflowing
	function automatic int draw_size();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return $urandom_range(8, 1);
		if (r < 80)
			return $urandom_range(CAPACITY - 1, 9);
		if (r < 90)
			return CAPACITY;
		return $urandom_range(CAPACITY + 8, CAPACITY + 1);
	endfunction

	// one input transaction, held until accepted
	task automatic drive_item(q16_t v, logic fin);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		sample     <= v;
		final_item <= fin;
		do @(posedge clk); while (busy);
		sb.note_sample(v, fin);
	endtask

	task automatic send_set(int n);
		int k;
		for (k = 0; k < n; k++)
			drive_item(draw_value(), k == n - 1);
	endtask

	task automatic write_order(bit desc);
		cfg_we    <= 1'b1;
		cfg_wdata <= desc;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_order(desc);
	endtask

	// wait for every expected result and for the block to go idle
	task automatic drain();
		start <= 1'b0;
		while (sb.expected_sorted.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		bit   phase_desc[4];
		int   phase_idle[4];
		int   phase_first[4];
		q16_t mixed[6];
		int   p;
		int   k;
		int   n;
		int   sent;
		phase_desc  = '{1'b0, 1'b1, 1'b0, 1'b1};
		phase_idle  = '{0, 68, 14, 0};
		phase_first = '{0, CAPACITY + 1, CAPACITY, CAPACITY + 8};
		mixed = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000,
			32'shffff_ffff, 32'sh0000_0001, 32'sh7fff_ffff};

		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = 1'b0;
		start      = 1'b0;
		sample     = '0;
		final_item = 1'b0;
		cycles     = 0;
		idle_pct   = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (p = 0; p < 4; p++) begin
			write_order(phase_desc[p]);
			idle_pct = phase_idle[p];
			sent = 0;
			if (p == 0) begin
				// single most negative value
				drive_item(32'sh8000_0000, 1'b1);
				// field extremes with a repeated maximum
				for (k = 0; k < 6; k++)
					drive_item(mixed[k], k == 5);
				// +1.0, -1.0, +1.0 in q16.16
				drive_item(32'sh0001_0000, 1'b0);
				drive_item(32'shffff_0000, 1'b0);
				drive_item(32'sh0001_0000, 1'b1);
				// already in reverse order
				drive_item(32'sh0000_0005, 1'b0);
				drive_item(-32'sh0000_0005, 1'b1);
				sent = 12;
			end else begin
				// full store, with the closing value discarded or exactly fitting
				send_set(phase_first[p]);
				sent = phase_first[p];
			end
			while (sent < PHASE_ITEMS) begin
				n = draw_size();
				send_set(n);
				sent += n;
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		while (sb.expected_sorted.size() != 0) begin
			sb.report_mismatch($sformatf("missing result %h", sb.expected_sorted[0].value));
			void'(sb.expected_sorted.pop_front());
		end

		$display("covered %0d transactions in %0d sets, %0d of them overflowing the store",
			sb.items, sb.sets, sb.overflow_sets);
		$display("checked %0d sorted results in both orders, %0d mismatches",
			sb.checked, sb.mismatches);
		if (sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
